/* design/obht_pkg.sv */
// Package for the ordered bucket hash table: sizes, derived widths,
// character constants and the byte mixing function.
// No dependencies.
package obht_pkg;

	localparam int BOX_COUNT       = 256;
	localparam int SLOTS_PER_BOX   = 8;
	localparam int LABEL_MAX_BYTES = 8;

	localparam int STORE_DEPTH = BOX_COUNT * SLOTS_PER_BOX;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int BOX_W       = $clog2(BOX_COUNT);
	localparam int CNT_W       = $clog2(SLOTS_PER_BOX + 1);
	localparam int ENTRY_W     = 64 + 4 + 4;
	localparam int FSUM_W      = 8;
	localparam int PROD_W      = 10;
	localparam int WPROD_W     = PROD_W + BOX_W + 1;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_EQUAL = 8'h3d;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// one hash step: (h + c) * 17 mod 256
	function automatic logic [7:0] mix_char(input logic [7:0] h, input logic [7:0] c);
		logic [7:0] s;
		s = h + c;
		return {s[3:0], 4'h0} + s;
	endfunction

endpackage

/* design/obht_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module obht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/ordered_bucket_hash_table.sv */
// Ordered bucket hash table. One beat is accepted in the idle cycle. It then hashes the
// label and looks up the box count, reads and compares the slots of the box in turn until a
// match or the search runs past the last entry, and decides. On a remove it shifts the later
// entries down and closes the shift; then it settles the totals. No new beat is taken until
// the step is done. Every slot visit goes through the single read port of the entry memory.
// A stalled result holds the next step in its last cycle. Uses obht_pkg and obht_ram.
// Box counts live in a RAM with one valid flop per box, so no clearing pass is needed.
module ordered_bucket_hash_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] label_bytes,
	input  logic [3:0]  label_length,
	input  logic [3:0]  focal_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  box_index,
	output logic [7:0]  step_hash,
	output logic [31:0] step_hash_total,
	output logic [23:0] weighted_total,
	output logic        box_overflow
);
	import obht_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_CNT, S_CNT_WT, S_SLOT_RD, S_SLOT_CMP, S_DECIDE,
		S_SHIFT_RD, S_SHIFT_WR, S_PROD, S_MUL, S_FIN
	} state_t;

	state_t state_q;
	logic [63:0]        label_q;
	logic [3:0]         len_q, focal_q, idx_q, old_q;
	logic [7:0]         h_q, sh_q;
	logic [CNT_W-1:0]   cnt_q, slot_q;
	logic               found_q, ovf_q;
	logic [FSUM_W-1:0]  fsum_q;
	logic [PROD_W-1:0]  sub_q, add_q;
	logic [WPROD_W-1:0] subw_q, addw_q;
	logic [23:0]        ws_q;
	logic [31:0]        hs_q;
	logic [BOX_COUNT-1:0] cnt_vld_q;

	// memories
	logic               e_we, c_we;
	logic [ADDR_W-1:0]  e_waddr, e_raddr;
	logic [ENTRY_W-1:0] e_wdata, e_rdata;
	logic [CNT_W-1:0]   c_wdata, c_rdata;

	obht_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_entry_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata));

	obht_ram #(.WIDTH(CNT_W), .DEPTH(BOX_COUNT)) u_count_ram (
		.clk(clk), .we(c_we), .waddr(h_q), .wdata(c_wdata),
		.raddr(h_q), .rdata(c_rdata));

	// input masking and length saturation
	logic [3:0]  len_sat;
	logic [63:0] label_m;
	always_comb begin
		len_sat = (label_length > 4'(LABEL_MAX_BYTES)) ? 4'(LABEL_MAX_BYTES) : label_length;
		for (int b = 0; b < 8; b++) begin
			label_m[8*b +: 8] = (4'(b) < len_sat) ? label_bytes[8*b +: 8] : 8'h00;
		end
	end

	logic [ADDR_W-1:0] base;
	logic [CNT_W-1:0]  cnt_now, slot_m1;
	logic [7:0]        sh_next;
	logic [32:0]       hs_sum;
	logic [8:0]        wbox;
	logic              label_hit;
	always_comb begin
		base    = ADDR_W'(h_q) * ADDR_W'(SLOTS_PER_BOX);
		cnt_now = !cnt_vld_q[h_q] ? '0 :
		          (c_rdata > CNT_W'(SLOTS_PER_BOX)) ? CNT_W'(SLOTS_PER_BOX) : c_rdata;
		slot_m1 = slot_q - 1'b1;
		sh_next = (focal_q == 4'd0) ? mix_char(h_q, CH_MINUS) :
		          mix_char(mix_char(h_q, CH_EQUAL), CH_ZERO + 8'(focal_q));
		hs_sum  = {1'b0, hs_q} + 33'(sh_q);
		wbox    = {1'b0, h_q} + 9'd1;
		label_hit = (e_rdata[71:8] == label_q) && (e_rdata[7:4] == len_q);
	end

	// memory port control
	always_comb begin
		e_we    = 1'b0;
		c_we    = 1'b0;
		e_waddr = base + ADDR_W'(slot_q);
		e_wdata = {label_q, len_q, focal_q};
		e_raddr = base + ADDR_W'(slot_q);
		c_wdata = cnt_q;
		case (state_q)
			S_DECIDE: begin
				if (focal_q != 4'd0 && found_q) begin
					e_we = 1'b1;
				end else if (focal_q != 4'd0 && cnt_q < CNT_W'(SLOTS_PER_BOX)) begin
					e_we    = 1'b1;
					c_we    = 1'b1;
					c_wdata = cnt_q + 1'b1;
				end
			end
			S_SHIFT_RD: begin
				if (slot_q >= cnt_q) begin
					c_we    = 1'b1;
					c_wdata = cnt_q - 1'b1;
				end
			end
			S_SHIFT_WR: begin
				e_we    = 1'b1;
				e_waddr = base + ADDR_W'(slot_m1);
				e_wdata = e_rdata;
			end
			default: ;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// last cycle of a step completes when the output register is free
	logic fin_go;
	assign fin_go = (state_q == S_FIN) && (!out_valid || !out_stall);

	// sequencer, totals and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_vld_q <= '0;
			ws_q      <= '0;
			hs_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			if (c_we) begin
				cnt_vld_q[h_q] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						label_q <= label_m;
						len_q   <= len_sat;
						focal_q <= focal_length;
						h_q     <= '0;
						idx_q   <= '0;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (idx_q < len_q) begin
						h_q   <= mix_char(h_q, label_q[8*idx_q[2:0] +: 8]);
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= S_CNT;
					end
				end
				S_CNT: begin
					sh_q    <= sh_next;
					state_q <= S_CNT_WT;
				end
				S_CNT_WT: begin
					cnt_q   <= cnt_now;
					slot_q  <= '0;
					found_q <= 1'b0;
					ovf_q   <= 1'b0;
					fsum_q  <= '0;
					state_q <= S_SLOT_RD;
				end
				S_SLOT_RD: begin
					state_q <= (slot_q < cnt_q) ? S_SLOT_CMP : S_DECIDE;
				end
				S_SLOT_CMP: begin
					if (label_hit) begin
						found_q <= 1'b1;
						old_q   <= e_rdata[3:0];
						// keep the match slot for the weight update after a shift
						idx_q   <= slot_q;
						state_q <= S_DECIDE;
					end else begin
						slot_q  <= slot_q + 1'b1;
						state_q <= S_SLOT_RD;
					end
				end
				S_DECIDE: begin
					if (focal_q == 4'd0) begin
						if (found_q) begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_SHIFT_RD;
						end else begin
							old_q   <= '0;
							state_q <= S_PROD;
						end
					end else begin
						if (!found_q) begin
							old_q <= '0;
							if (cnt_q >= CNT_W'(SLOTS_PER_BOX)) begin
								ovf_q <= 1'b1;
							end
						end
						state_q <= S_PROD;
					end
				end
				S_SHIFT_RD: begin
					state_q <= (slot_q < cnt_q) ? S_SHIFT_WR : S_PROD;
					if (slot_q >= cnt_q) begin
						slot_q <= idx_q;
					end
				end
				S_SHIFT_WR: begin
					fsum_q  <= fsum_q + FSUM_W'(e_rdata[3:0]);
					slot_q  <= slot_q + 1'b1;
					state_q <= S_SHIFT_RD;
				end
				S_PROD: begin
					// slot_q holds the match slot, or the count for an append
					sub_q   <= PROD_W'(slot_q + 1'b1) * PROD_W'(old_q) + PROD_W'(fsum_q);
					add_q   <= (focal_q == 4'd0 || ovf_q) ? '0 :
					           PROD_W'(slot_q + 1'b1) * PROD_W'(focal_q);
					state_q <= S_MUL;
				end
				S_MUL: begin
					subw_q  <= WPROD_W'(wbox) * WPROD_W'(sub_q);
					addw_q  <= WPROD_W'(wbox) * WPROD_W'(add_q);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						ws_q            <= ws_q - 24'(subw_q) + 24'(addw_q);
						hs_q            <= hs_sum[32] ? '1 : hs_sum[31:0];
						step_hash_total <= hs_sum[32] ? '1 : hs_sum[31:0];
						weighted_total  <= ws_q - 24'(subw_q) + 24'(addw_q);
						box_index       <= h_q;
						step_hash       <= sh_q;
						box_overflow    <= ovf_q;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		c_we |-> c_wdata <= CNT_W'(SLOTS_PER_BOX))
		else $error("box count written beyond slot limit");
	a_accept_hash: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_HASH)
		else $error("accepted beat did not start hashing");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_valid) |=> out_valid)
		else $error("finished step not presented");
	a_shift_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT_WR) |-> (focal_q == 4'd0 && found_q))
		else $error("entry shift outside a remove");

endmodule
